>>> rtl/core/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int OPW    = 32;
	localparam int PW     = 2 * OPW;
	localparam int CW     = $clog2(PW);
	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);

	localparam logic [PW-1:0] LIM = (PW'(1) << (OPW - 1)) - PW'(1);

	typedef enum logic [2:0] {
		ACT_NORM = 3'd0,
		ACT_ADD  = 3'd1,
		ACT_SUB  = 3'd2,
		ACT_MUL  = 3'd3,
		ACT_DIV  = 3'd4,
		ACT_CMP  = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZDEN = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [31:0] a_num;
		logic signed [31:0] a_den;
		logic signed [31:0] b_num;
		logic signed [31:0] b_den;
	} in_t;

	typedef struct packed {
		logic signed [31:0] res_num;
		logic [30:0]        res_den;
		logic               is_equal;
		status_t            status;
	} out_t;

	typedef struct packed {
		action_t          op;
		logic             an_neg;
		logic [OPW-1:0]   an_mag;
		logic             ad_neg;
		logic [OPW-1:0]   ad_mag;
		logic             bn_neg;
		logic [OPW-1:0]   bn_mag;
		logic             bd_neg;
		logic [OPW-1:0]   bd_mag;
	} item_t;

	typedef struct packed {
		logic          start;
		logic          n_neg;
		logic [PW-1:0] n_mag;
		logic          d_neg;
		logic [PW-1:0] d_mag;
	} norm_req_t;

	typedef struct packed {
		logic          done;
		logic          busy;
		logic          neg;
		logic [PW-1:0] n_mag;
		logic [PW-1:0] d_mag;
	} norm_rsp_t;

endpackage

>>> rtl/core/rau_front.sv
// ----------------------------------------------------------------------------
// rau_front
// Input stage: takes a beat, decodes the action and splits operands into
// sign and magnitude.
// ----------------------------------------------------------------------------
module rau_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rau_pkg::in_t   in_data,
	output logic           push,
	output rau_pkg::item_t push_data,
	input  logic           full
);

	function automatic logic [rau_pkg::OPW:0] split(input logic [31:0] raw);
		logic [rau_pkg::OPW-1:0] v;
		logic                    n;
		v = raw[rau_pkg::OPW-1:0];
		n = v[rau_pkg::OPW-1];
		return {n, (n ? (~v + rau_pkg::OPW'(1)) : v)};
	endfunction

	logic           valid_s1;
	rau_pkg::item_t item_s1;
	rau_pkg::item_t item_d;

	always_comb begin
		item_d = '0;
		unique case (in_data.action)
			3'd0: item_d.op = rau_pkg::ACT_NORM;
			3'd1: item_d.op = rau_pkg::ACT_ADD;
			3'd2: item_d.op = rau_pkg::ACT_SUB;
			3'd3: item_d.op = rau_pkg::ACT_MUL;
			3'd4: item_d.op = rau_pkg::ACT_DIV;
			default: item_d.op = rau_pkg::ACT_CMP;
		endcase
		{item_d.an_neg, item_d.an_mag} = split(in_data.a_num);
		{item_d.ad_neg, item_d.ad_mag} = split(in_data.a_den);
		{item_d.bn_neg, item_d.bn_mag} = split(in_data.b_num);
		{item_d.bd_neg, item_d.bd_mag} = split(in_data.b_den);
	end

	assign in_ready  = !valid_s1 || !full;
	assign push      = valid_s1 && !full;
	assign push_data = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_d;
		end
	end

endmodule

>>> rtl/core/rau_fifo.sv
// ----------------------------------------------------------------------------
// rau_fifo
// Short queue of decoded items between front and back.
// ----------------------------------------------------------------------------
module rau_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rau_pkg::item_t push_data,
	output logic           full,
	input  logic           pop,
	output rau_pkg::item_t pop_data,
	output logic           empty
);

	rau_pkg::item_t           mem_q [rau_pkg::QDEPTH];
	logic [rau_pkg::QAW-1:0]  wr_ptr_q;
	logic [rau_pkg::QAW-1:0]  rd_ptr_q;
	logic [rau_pkg::QAW:0]    cnt_q;

	assign full     = (cnt_q == (rau_pkg::QAW+1)'(rau_pkg::QDEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + rau_pkg::QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + rau_pkg::QAW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (rau_pkg::QAW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (rau_pkg::QAW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue push while full");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue pop while empty");

endmodule

>>> rtl/core/rau_norm.sv
// ----------------------------------------------------------------------------
// rau_norm
// Fraction normalizer: binary gcd one step a cycle, then restoring division
// of numerator and denominator by the gcd side by side.
// ----------------------------------------------------------------------------
module rau_norm (
	input  logic               clk,
	input  logic               arst_n,
	input  rau_pkg::norm_req_t req,
	output rau_pkg::norm_rsp_t rsp
);

	typedef enum logic [1:0] {N_IDLE, N_GCD, N_DIV} nstate_t;

	nstate_t                state_q;
	logic [rau_pkg::PW-1:0] x_q, y_q, nm_q, dm_q, g_q, rn_q, rd_q;
	logic [rau_pkg::CW-1:0] k_q, cnt_q;
	logic                   neg_q;
	logic                   done_q, on_neg_q;
	logic [rau_pkg::PW-1:0] on_mag_q, od_mag_q;

	logic                   gcd_end;
	logic [rau_pkg::PW-1:0] g_c;
	logic [rau_pkg::PW:0]   tn, td, sn, sd;
	logic                   ge_n, ge_d;

	always_comb begin
		gcd_end = (x_q == '0) || (y_q == '0);
		g_c     = (x_q | y_q) << k_q;
		tn      = {rn_q, nm_q[rau_pkg::PW-1]};
		td      = {rd_q, dm_q[rau_pkg::PW-1]};
		ge_n    = tn >= {1'b0, g_q};
		ge_d    = td >= {1'b0, g_q};
		sn      = tn - {1'b0, g_q};
		sd      = td - {1'b0, g_q};
	end

	assign rsp.done  = done_q;
	assign rsp.busy  = (state_q != N_IDLE);
	assign rsp.neg   = on_neg_q;
	assign rsp.n_mag = on_mag_q;
	assign rsp.d_mag = od_mag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				N_IDLE: begin
					if (req.start) begin
						if (req.n_mag == '0 || req.d_mag == '0) begin
							on_neg_q <= 1'b0;
							on_mag_q <= req.n_mag;
							od_mag_q <= (req.n_mag == '0) ? rau_pkg::PW'(1) : req.d_mag;
							done_q   <= 1'b1;
						end else begin
							x_q     <= req.n_mag;
							y_q     <= req.d_mag;
							nm_q    <= req.n_mag;
							dm_q    <= req.d_mag;
							k_q     <= '0;
							neg_q   <= req.n_neg ^ req.d_neg;
							state_q <= N_GCD;
						end
					end
				end
				N_GCD: begin
					if (gcd_end) begin
						if (g_c == rau_pkg::PW'(1)) begin
							on_neg_q <= neg_q;
							on_mag_q <= nm_q;
							od_mag_q <= dm_q;
							done_q   <= 1'b1;
							state_q  <= N_IDLE;
						end else begin
							g_q     <= g_c;
							rn_q    <= '0;
							rd_q    <= '0;
							cnt_q   <= '0;
							state_q <= N_DIV;
						end
					end else if (!x_q[0] && !y_q[0]) begin
						x_q <= x_q >> 1;
						y_q <= y_q >> 1;
						k_q <= k_q + rau_pkg::CW'(1);
					end else if (!x_q[0]) begin
						x_q <= x_q >> 1;
					end else if (!y_q[0]) begin
						y_q <= y_q >> 1;
					end else if (x_q >= y_q) begin
						x_q <= x_q - y_q;
					end else begin
						y_q <= y_q - x_q;
					end
				end
				N_DIV: begin
					nm_q  <= {nm_q[rau_pkg::PW-2:0], ge_n};
					dm_q  <= {dm_q[rau_pkg::PW-2:0], ge_d};
					rn_q  <= ge_n ? sn[rau_pkg::PW-1:0] : tn[rau_pkg::PW-1:0];
					rd_q  <= ge_d ? sd[rau_pkg::PW-1:0] : td[rau_pkg::PW-1:0];
					cnt_q <= cnt_q + rau_pkg::CW'(1);
					if (cnt_q == rau_pkg::CW'(rau_pkg::PW - 1)) begin
						on_neg_q <= neg_q;
						on_mag_q <= {nm_q[rau_pkg::PW-2:0], ge_n};
						od_mag_q <= {dm_q[rau_pkg::PW-2:0], ge_d};
						done_q   <= 1'b1;
						state_q  <= N_IDLE;
					end
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done_q |=> !done_q)
		else $error("normalizer done held longer than one cycle");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> (state_q == N_IDLE))
		else $error("normalizer started while busy");

endmodule

>>> rtl/core/rau_back.sv
// ----------------------------------------------------------------------------
// rau_back
// Execution sequencer: normalizes both operands, forms the products on one
// multiplier, combines, normalizes a non-compare result and holds the output.
// ----------------------------------------------------------------------------
module rau_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  rau_pkg::item_t     pop_data,
	output logic               pop,
	output rau_pkg::norm_req_t nreq,
	input  rau_pkg::norm_rsp_t nrsp,
	output logic               out_valid,
	input  logic               out_ready,
	output rau_pkg::out_t      out_data
);

	typedef enum logic [3:0] {
		B_IDLE, B_NA_GO, B_NA_WAIT, B_NB_GO, B_NB_WAIT, B_MUL, B_COMB,
		B_NR_GO, B_NR_WAIT, B_OUT
	} bstate_t;

	bstate_t                 state_q;
	rau_pkg::item_t          it_q;
	logic                    an_neg_q, bn_neg_q;
	logic [rau_pkg::OPW-1:0] an_q, ad_q, bn_q, bd_q;
	logic [rau_pkg::PW-1:0]  p_q [4];
	logic [1:0]              mcnt_q;
	logic                    pn_neg_q, pd_neg_q, eq_q, arith_q;
	logic [rau_pkg::PW-1:0]  pn_q, pd_q;
	logic                    rn_neg_q;
	logic [rau_pkg::PW-1:0]  rn_q, rd_q;
	logic                    out_valid_q;
	rau_pkg::out_t           out_q;

	logic [rau_pkg::OPW-1:0] ma, mb;
	logic [rau_pkg::PW-1:0]  prod;
	logic                    s1;
	logic                    sum_neg;
	logic [rau_pkg::PW-1:0]  sum_mag;
	logic                    cn_neg, cd_neg;
	logic [rau_pkg::PW-1:0]  cn_mag, cd_mag;
	logic                    eq_c;
	logic [31:0]             num32;
	rau_pkg::out_t           res_c;

	assign pop       = (state_q == B_IDLE) && !empty;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		nreq = '0;
		unique case (state_q)
			B_NA_GO: begin
				nreq.start = 1'b1;
				nreq.n_neg = it_q.an_neg;
				nreq.n_mag = rau_pkg::PW'(it_q.an_mag);
				nreq.d_neg = it_q.ad_neg;
				nreq.d_mag = rau_pkg::PW'(it_q.ad_mag);
			end
			B_NB_GO: begin
				nreq.start = 1'b1;
				nreq.n_neg = it_q.bn_neg;
				nreq.n_mag = rau_pkg::PW'(it_q.bn_mag);
				nreq.d_neg = it_q.bd_neg;
				nreq.d_mag = rau_pkg::PW'(it_q.bd_mag);
			end
			B_NR_GO: begin
				nreq.start = 1'b1;
				nreq.n_neg = pn_neg_q;
				nreq.n_mag = pn_q;
				nreq.d_neg = pd_neg_q;
				nreq.d_mag = pd_q;
			end
			default: nreq = '0;
		endcase
	end

	always_comb begin
		unique case (mcnt_q)
			2'd0: begin ma = an_q; mb = bd_q; end
			2'd1: begin ma = bn_q; mb = ad_q; end
			2'd2: begin ma = an_q; mb = bn_q; end
			default: begin ma = ad_q; mb = bd_q; end
		endcase
		prod = rau_pkg::PW'(ma) * rau_pkg::PW'(mb);
	end

	always_comb begin
		s1 = (it_q.op == rau_pkg::ACT_SUB) ? !bn_neg_q : bn_neg_q;
		if (an_neg_q == s1) begin
			sum_mag = p_q[0] + p_q[1];
			sum_neg = an_neg_q;
		end else if (p_q[0] >= p_q[1]) begin
			sum_mag = p_q[0] - p_q[1];
			sum_neg = an_neg_q;
		end else begin
			sum_mag = p_q[1] - p_q[0];
			sum_neg = s1;
		end
		eq_c = (p_q[0] == p_q[1]) && ((p_q[0] == '0) || (an_neg_q == bn_neg_q));
		cd_neg = 1'b0;
		cd_mag = p_q[3];
		unique case (it_q.op)
			rau_pkg::ACT_NORM: begin
				cn_neg = an_neg_q;
				cn_mag = rau_pkg::PW'(an_q);
				cd_mag = rau_pkg::PW'(ad_q);
			end
			rau_pkg::ACT_ADD, rau_pkg::ACT_SUB: begin
				cn_neg = sum_neg;
				cn_mag = sum_mag;
			end
			rau_pkg::ACT_MUL: begin
				cn_neg = an_neg_q ^ bn_neg_q;
				cn_mag = p_q[2];
			end
			rau_pkg::ACT_DIV: begin
				cn_neg = an_neg_q;
				cn_mag = p_q[0];
				cd_neg = bn_neg_q;
				cd_mag = p_q[1];
			end
			default: begin
				cn_neg = 1'b0;
				cn_mag = '0;
			end
		endcase
	end

	always_comb begin
		num32          = 32'(rn_q);
		res_c.is_equal = eq_q;
		if (!arith_q) begin
			res_c.res_num = '0;
			res_c.res_den = 31'd1;
			res_c.status  = rau_pkg::ST_OK;
		end else if (rn_q > rau_pkg::LIM || rd_q > rau_pkg::LIM) begin
			res_c.res_num = '0;
			res_c.res_den = '0;
			res_c.status  = rau_pkg::ST_OVF;
		end else begin
			res_c.res_num = rn_neg_q ? (32'd0 - num32) : num32;
			res_c.res_den = 31'(rd_q);
			res_c.status  = (rd_q == '0) ? rau_pkg::ST_ZDEN : rau_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			mcnt_q      <= '0;
		end else begin
			if (out_valid_q && out_ready && (state_q != B_OUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (!empty) begin
						it_q    <= pop_data;
						state_q <= B_NA_GO;
					end
				end
				B_NA_GO: state_q <= B_NA_WAIT;
				B_NA_WAIT: begin
					if (nrsp.done) begin
						an_neg_q <= nrsp.neg;
						an_q     <= nrsp.n_mag[rau_pkg::OPW-1:0];
						ad_q     <= nrsp.d_mag[rau_pkg::OPW-1:0];
						state_q  <= B_NB_GO;
					end
				end
				B_NB_GO: state_q <= B_NB_WAIT;
				B_NB_WAIT: begin
					if (nrsp.done) begin
						bn_neg_q <= nrsp.neg;
						bn_q     <= nrsp.n_mag[rau_pkg::OPW-1:0];
						bd_q     <= nrsp.d_mag[rau_pkg::OPW-1:0];
						mcnt_q   <= '0;
						state_q  <= B_MUL;
					end
				end
				B_MUL: begin
					p_q[mcnt_q] <= prod;
					mcnt_q      <= mcnt_q + 2'd1;
					if (mcnt_q == 2'd3) begin
						state_q <= B_COMB;
					end
				end
				B_COMB: begin
					pn_neg_q <= cn_neg;
					pn_q     <= cn_mag;
					pd_neg_q <= cd_neg;
					pd_q     <= cd_mag;
					eq_q     <= eq_c;
					arith_q  <= (it_q.op != rau_pkg::ACT_CMP);
					state_q  <= (it_q.op != rau_pkg::ACT_CMP) ? B_NR_GO : B_OUT;
				end
				B_NR_GO: state_q <= B_NR_WAIT;
				B_NR_WAIT: begin
					if (nrsp.done) begin
						rn_neg_q <= nrsp.neg;
						rn_q     <= nrsp.n_mag;
						rd_q     <= nrsp.d_mag;
						state_q  <= B_OUT;
					end
				end
				B_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_q       <= res_c;
						out_valid_q <= 1'b1;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/rational_arithmetic_unit_top.sv
// path: a front register and the queue lie ahead of the back-end sequencer, which makes
// three normalizer passes (operand a, operand b, result; compare skips the result pass);
// a pass skips the gcd when a part is zero, else runs binary gcd steps and then restoring
// division steps, with no division when the gcd is 1
// flow: the back end runs one item at a time and pops the next only once back in idle
// reset: arst_n clears control state only; no clearing pass
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Rational add, subtract, multiply, divide, compare and normalize with gcd reduction.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rau_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output rau_pkg::out_t out_data
);

	logic               push, full, pop, empty;
	rau_pkg::item_t     push_data, pop_data;
	rau_pkg::norm_req_t nreq;
	rau_pkg::norm_rsp_t nrsp;

	rau_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	rau_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	rau_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (nreq),
		.rsp    (nrsp)
	);

	rau_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.pop_data  (pop_data),
		.pop       (pop),
		.nreq      (nreq),
		.nrsp      (nrsp),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
